// ===== sv/gbhp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbhp_pkg: shared types and constants of the geometry blob header parser
// Holds the queue record, status codes and the IEEE helper functions.
// ----------------------------------------------------------------------------
package gbhp_pkg;

    localparam logic [7:0] MAGIC_FIRST  = 8'h47;
    localparam logic [7:0] MAGIC_SECOND = 8'h50;
    localparam logic [2:0] MAX_CODE     = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_VER   = 3'd2;
    localparam logic [2:0] ST_BAD_CODE  = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_INV_ENV   = 3'd5;

    localparam int OUT_DATA_W = 184;

    // one parsed byte: an optional range result and an optional status result
    typedef struct packed {
        logic        rng_v;
        logic        sts_v;
        logic [1:0]  axis;
        logic [63:0] mn;
        logic [63:0] mx;
        logic [2:0]  status;
        logic        is_empty;
        logic [2:0]  env_kind;
        logic        little;
        logic [31:0] srid;
        logic [6:0]  hb_rng;
        logic [6:0]  hb_sts;
    } t_rec;

    // header length for an envelope code
    function automatic logic [6:0] hdr_len(input logic [2:0] code);
        unique case (code)
            3'd0:    hdr_len = 7'd8;
            3'd1:    hdr_len = 7'd40;
            3'd4:    hdr_len = 7'd72;
            default: hdr_len = 7'd56;
        endcase
    endfunction

    // number of axes for an envelope code
    function automatic logic [2:0] axes_of(input logic [2:0] code);
        unique case (code)
            3'd0:    axes_of = 3'd0;
            3'd1:    axes_of = 3'd2;
            3'd4:    axes_of = 3'd4;
            default: axes_of = 3'd3;
        endcase
    endfunction

    function automatic logic is_nan(input logic [63:0] v);
        is_nan = (&v[62:52]) && (|v[51:0]);
    endfunction

    // IEEE a > b on raw double bits, false when either is NaN
    function automatic logic dbl_gt(input logic [63:0] a, input logic [63:0] b);
        logic both_zero;
        logic res;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (is_nan(a) || is_nan(b) || both_zero) begin
            res = 1'b0;
        end else if (a[63] != b[63]) begin
            res = !a[63];
        end else if (!a[63]) begin
            res = a[62:0] > b[62:0];
        end else begin
            res = a[62:0] < b[62:0];
        end
        dbl_gt = res;
    endfunction

endpackage

// ===== sv/gbhp_front.sv =====
// ----------------------------------------------------------------------------
// gbhp_front: byte parser
// Checks magic, version and flags, assembles SRID and envelope doubles and
// writes one record per byte that yields a result.
// ----------------------------------------------------------------------------
module gbhp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_sob,
    input  logic           i_eob,
    input  logic           i_full,
    output logic           o_push,
    output gbhp_pkg::t_rec o_rec
);
    import gbhp_pkg::*;

    logic [6:0]  r_pos,   n_pos;
    logic [4:0]  r_flags, n_flags;
    logic [63:0] r_asm,   n_asm;
    logic [31:0] r_srid,  n_srid;
    logic [63:0] r_hmin,  n_hmin;
    logic        r_err,   n_err;
    logic        r_fin,   n_fin;

    logic        acc;
    logic        active;
    logic [6:0]  p;
    logic [4:0]  flg;
    logic [63:0] asm_w;
    logic [63:0] sh_w;
    logic [2:0]  code;
    logic        seen;
    logic        sts_v;
    logic [2:0]  st;
    logic        rng_v;
    logic        bad_pair;
    logic [6:0]  off;
    logic [2:0]  pair;
    logic        done;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign active  = i_sob || !r_fin;

    // shift one byte into the assembly word in the header byte order
    always_comb begin
        p     = i_sob ? 7'd0 : r_pos;
        flg   = i_sob ? 5'd0 : r_flags;
        asm_w = i_sob ? 64'd0 : r_asm;
        if (p[2:0] == 3'd0 || (p[6:3] == 4'd0 && p[1:0] == 2'd0)) begin
            asm_w = 64'd0;
        end
        if (flg[0]) begin
            if (p[6:3] == 4'd0) begin
                sh_w = asm_w | (64'(i_byte) << {p[1:0], 3'b000});
            end else begin
                sh_w = asm_w | (64'(i_byte) << {p[2:0], 3'b000});
            end
        end else begin
            sh_w = {asm_w[55:0], i_byte};
        end
    end

    // per-byte decode
    always_comb begin
        n_pos    = r_pos;
        n_flags  = i_sob ? 5'd0 : r_flags;
        n_asm    = i_sob ? 64'd0 : r_asm;
        n_srid   = i_sob ? 32'd0 : r_srid;
        n_hmin   = i_sob ? 64'd0 : r_hmin;
        n_err    = i_sob ? 1'b0 : r_err;
        n_fin    = r_fin;
        sts_v    = 1'b0;
        st       = ST_OK;
        rng_v    = 1'b0;
        bad_pair = 1'b0;
        off      = p - 7'd8;
        pair     = off[6:4];
        code     = flg[3:1];
        done     = 1'b0;
        if (p == 7'd0) begin
            n_asm = {56'd0, i_byte};
        end else if (p == 7'd1) begin
            if (!(r_asm[7:0] == MAGIC_FIRST && r_asm[63:8] == 56'd0 &&
                  i_byte == MAGIC_SECOND)) begin
                sts_v = 1'b1;
                st    = ST_BAD_MAGIC;
            end
        end else if (p == 7'd2) begin
            if (i_byte != 8'd0) begin
                sts_v = 1'b1;
                st    = ST_BAD_VER;
            end
        end else if (p == 7'd3) begin
            code = i_byte[3:1];
            if (code > MAX_CODE) begin
                sts_v   = 1'b1;
                st      = ST_BAD_CODE;
                n_flags = i_byte[4:0] & 5'h11;
            end else begin
                n_flags = i_byte[4:0];
            end
        end else if (p < 7'd8) begin
            n_asm = sh_w;
            if (p == 7'd7) begin
                n_srid = sh_w[31:0];
                if (code == 3'd0) begin
                    sts_v = 1'b1;
                    st    = n_err ? ST_INV_ENV : ST_OK;
                end
            end
        end else begin
            n_asm = sh_w;
            if (off[3:0] == 4'd7) begin
                n_hmin = sh_w;
            end else if (off[3:0] == 4'd15) begin
                rng_v    = 1'b1;
                bad_pair = (flg[4] && (!is_nan(n_hmin) || !is_nan(sh_w))) ||
                           dbl_gt(n_hmin, sh_w);
                n_err    = n_err | bad_pair;
                done     = ({1'b0, pair} + 4'd1) >= {1'b0, axes_of(code)};
                if (done) begin
                    sts_v = 1'b1;
                    st    = n_err ? ST_INV_ENV : ST_OK;
                end
            end
        end
        if (!sts_v && i_eob) begin
            sts_v = 1'b1;
            st    = ST_TRUNC;
        end
        if (sts_v) begin
            n_fin = 1'b1;
        end else begin
            n_pos = p + 7'd1;
            n_fin = 1'b0;
        end
    end

    // record fields
    always_comb begin
        seen           = p >= 7'd3;
        o_rec.rng_v    = rng_v;
        o_rec.sts_v    = sts_v;
        o_rec.axis     = (pair == 3'd2 && n_flags[3:1] == 3'd3) ? 2'd3 : pair[1:0];
        o_rec.mn       = n_hmin;
        o_rec.mx       = sh_w;
        o_rec.status   = st;
        o_rec.is_empty = seen ? n_flags[4] : 1'b0;
        o_rec.env_kind = seen ? n_flags[3:1] : 3'd0;
        o_rec.little   = seen ? n_flags[0] : 1'b0;
        o_rec.srid     = n_srid;
        o_rec.hb_rng   = hdr_len(n_flags[3:1]);
        o_rec.hb_sts   = (seen && (st == ST_OK || st >= ST_TRUNC)) ?
                         hdr_len(n_flags[3:1]) : 7'd0;
        o_push         = acc && active && (rng_v || sts_v);
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 7'd0;
            r_flags <= 5'd0;
            r_asm   <= 64'd0;
            r_srid  <= 32'd0;
            r_hmin  <= 64'd0;
            r_err   <= 1'b0;
            r_fin   <= 1'b1;
        end else if (acc && active) begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_asm   <= n_asm;
            r_srid  <= n_srid;
            r_hmin  <= n_hmin;
            r_err   <= n_err;
            r_fin   <= n_fin;
        end
    end

endmodule

// ===== sv/gbhp_queue.sv =====
// ----------------------------------------------------------------------------
// gbhp_queue: record queue
// Small register queue that decouples the parser from the output side.
// ----------------------------------------------------------------------------
module gbhp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbhp_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output gbhp_pkg::t_rec o_rec
);
    import gbhp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rec   = r_mem[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== sv/gbhp_back.sv =====
// ----------------------------------------------------------------------------
// gbhp_back: result formatter
// Turns each queued record into one or two output transfers.
// ----------------------------------------------------------------------------
module gbhp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  gbhp_pkg::t_rec                      i_rec,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gbhp_pkg::OUT_DATA_W-1:0]     o_data,
    output logic                                o_kind,
    output logic                                o_last
);
    import gbhp_pkg::*;

    logic r_phase, n_phase;
    logic is_rng;
    logic xfer;

    assign o_valid = !i_empty;
    assign xfer    = o_valid && i_ready;
    assign is_rng  = i_rec.rng_v && !r_phase;
    assign o_pop   = xfer && !(is_rng && i_rec.sts_v);
    assign o_kind  = !is_rng;
    assign o_last  = is_rng ? !i_rec.sts_v : 1'b1;

    // payload packing: axis, min, max, status, empty, kind, little, srid, length
    always_comb begin
        o_data = {7'd0,
                  is_rng ? i_rec.hb_rng : i_rec.hb_sts,
                  i_rec.srid,
                  i_rec.little,
                  i_rec.env_kind,
                  i_rec.is_empty,
                  is_rng ? ST_OK : i_rec.status,
                  is_rng ? i_rec.mx : 64'd0,
                  is_rng ? i_rec.mn : 64'd0,
                  is_rng ? i_rec.axis : 2'd0};
    end

    // phase: range part of a two-result record already sent
    always_comb begin
        n_phase = r_phase;
        if (xfer) begin
            n_phase = is_rng && i_rec.sts_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

    a_phase_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (o_valid && i_rec.rng_v && i_rec.sts_v))
        else $error("phase set without a two-result record");
    a_range_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && is_rng && i_rec.sts_v) |=> (o_valid && o_kind))
        else $error("status does not follow range");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> o_last) else $error("status without last");

endmodule

// ===== sv/geometry_blob_header_parser.sv =====
// Results are held in the record queue. Throughput: one byte per cycle
//   while the queue is not full; a byte that yields a range and the final
//   status takes two output transfers, set by the single output port.
// Reset: synchronous active-low; the parser idles until a start-of-blob byte,
//   and the record queue is emptied.
// ----------------------------------------------------------------------------
// geometry_blob_header_parser: top level
// Byte stream in, envelope ranges and header status out.
// ----------------------------------------------------------------------------
module geometry_blob_header_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tuser,   // [0] start_of_blob
    input  logic         i_s_axis_tlast,   // end_of_blob
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [1:0] axis, [65:2] range_min, [129:66] range_max, [132:130] status,
    // [133] is_empty, [136:134] envelope_kind, [137] little_endian,
    // [169:138] srid, [176:170] header_bytes, [183:177] zero
    output logic [gbhp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser,   // [0] result_kind
    output logic         o_m_axis_tlast    // last
);
    import gbhp_pkg::*;

    t_rec w_rec_in;
    t_rec w_rec_out;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    gbhp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_sob   (i_s_axis_tuser),
        .i_eob   (i_s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_rec_in)
    );

    gbhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_rec   (w_rec_out)
    );

    gbhp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_rec   (w_rec_out),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_kind  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the geometry blob header parser
// Streams blobs into the parser, predicts every range and status transfer
// with an independent model and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb;
    import gbhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        kind;
        logic [1:0]  axis;
        logic [63:0] mn;
        logic [63:0] mx;
        logic [2:0]  status;
        logic        is_empty;
        logic [2:0]  env_kind;
        logic        little;
        logic [31:0] srid;
        logic [6:0]  hdr_bytes;
        logic        last;
    } t_hdr_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [7:0]   s_data;
    logic         s_user;
    logic         s_last;
    logic         m_valid;
    logic         m_ready;
    logic [OUT_DATA_W-1:0] m_data;
    logic         m_user;
    logic         m_last;

    // parser model state
    logic [6:0]   pm_pos;
    logic [4:0]   pm_flags;
    logic [63:0]  pm_word;
    logic [31:0]  pm_srid;
    logic [63:0]  pm_min;
    logic         pm_env_err;
    logic         pm_done;

    t_hdr_result  pending_results[$];
    int           mismatch_cnt;
    int           idle_cycles;
    int           sink_idle;
    bit           src_gaps;
    bit           sink_gaps;
    bit           sink_hold;
    logic [7:0]   blob[$];

    geometry_blob_header_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] data_byte
        .i_s_axis_tuser  (s_user),   // [0] start_of_blob
        .i_s_axis_tlast  (s_last),   // end_of_blob
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // axis, min, max, status, flags, srid, length
        .o_m_axis_tuser  (m_user),   // [0] result_kind
        .o_m_axis_tlast  (m_last)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int axis_count(input logic [2:0] code);
        case (code)
            3'd0:    return 0;
            3'd1:    return 2;
            3'd4:    return 4;
            default: return 3;
        endcase
    endfunction

    function automatic bit nan_bits(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    // IEEE greater-than on raw bits via real conversion
    function automatic bit greater_dbl(input logic [63:0] a, input logic [63:0] b);
        if (nan_bits(a) || nan_bits(b)) return 1'b0;
        return $bitstoreal(a) > $bitstoreal(b);
    endfunction

    function automatic logic [63:0] shift_byte(input logic [63:0] w, input int k,
                                               input logic [7:0] b, input bit le);
        logic [63:0] r;
        r = (k == 0) ? 64'd0 : w;
        if (le) r = r | (64'(b) << (8 * k));
        else    r = {r[55:0], b};
        return r;
    endfunction

    function automatic t_hdr_result make_result(input bit kind, input logic [1:0] ax,
            input logic [63:0] mn, input logic [63:0] mx, input logic [2:0] st,
            input bit last);
        t_hdr_result r;
        bit seen;
        seen = pm_pos >= 7'd3;
        r.kind      = kind;
        r.axis      = ax;
        r.mn        = mn;
        r.mx        = mx;
        r.status    = st;
        r.is_empty  = seen ? pm_flags[4] : 1'b0;
        r.env_kind  = seen ? pm_flags[3:1] : 3'd0;
        r.little    = seen ? pm_flags[0] : 1'b0;
        r.srid      = pm_srid;
        r.hdr_bytes = (seen && (st == ST_OK || st >= ST_TRUNC))
                      ? 7'(8 + 16 * axis_count(pm_flags[3:1])) : 7'd0;
        r.last      = last;
        return r;
    endfunction

    // advance the parser model by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input bit sob, input bit eob);
        int st;
        int p;
        int q;
        int pair;
        logic [2:0] code;
        logic [1:0] ax;
        bit le;
        bit fin;
        st = -1;
        if (sob) begin
            pm_pos = 0; pm_flags = 0; pm_word = 0; pm_srid = 0;
            pm_min = 0; pm_env_err = 0; pm_done = 0;
        end else if (pm_done) begin
            return;
        end
        p = pm_pos;
        code = pm_flags[3:1];
        le = pm_flags[0];
        if (p == 0) begin
            pm_word = 64'(b);
        end else if (p == 1) begin
            if (!(pm_word == 64'(MAGIC_FIRST) && b == MAGIC_SECOND)) st = ST_BAD_MAGIC;
        end else if (p == 2) begin
            if (b != 8'd0) st = ST_BAD_VER;
        end else if (p == 3) begin
            if (b[3:1] > MAX_CODE) begin
                st = ST_BAD_CODE;
                pm_flags = b[4:0] & 5'h11;
            end else begin
                pm_flags = b[4:0];
            end
        end else if (p < 8) begin
            pm_word = shift_byte(pm_word, p - 4, b, le);
            if (p == 7) begin
                pm_srid = pm_word[31:0];
                if (code == 3'd0) st = pm_env_err ? ST_INV_ENV : ST_OK;
            end
        end else begin
            q = (p - 8) & 15;
            pair = (p - 8) >> 4;
            pm_word = shift_byte(pm_word, q & 7, b, le);
            if (q == 7) begin
                pm_min = pm_word;
            end else if (q == 15) begin
                fin = (pair + 1) >= axis_count(code);
                ax = (pair == 2 && code == 3'd3) ? 2'd3 : 2'(pair);
                if ((pm_flags[4] && (!nan_bits(pm_min) || !nan_bits(pm_word)))
                        || greater_dbl(pm_min, pm_word))
                    pm_env_err = 1'b1;
                if (fin) st = pm_env_err ? ST_INV_ENV : ST_OK;
                pending_results.push_back(make_result(1'b0, ax, pm_min, pm_word, ST_OK,
                                                      !(fin || eob)));
            end
        end
        if (st < 0 && eob) st = ST_TRUNC;
        if (st >= 0) begin
            pending_results.push_back(make_result(1'b1, 2'd0, 64'd0, 64'd0, 3'(st), 1'b1));
            pm_done = 1'b1;
        end else begin
            pm_pos = 7'(p + 1);
        end
    endtask

    // send one byte, with an optional random gap first
    task automatic send_byte(input logic [7:0] b, input bit sob, input bit eob);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= sob;
        s_last  <= eob;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_byte(b, sob, eob);
    endtask

    task automatic send_blob();
        foreach (blob[i]) send_byte(blob[i], i == 0, i == blob.size() - 1);
    endtask

    function automatic logic [63:0] rand_double();
        case ($urandom_range(0, 5))
            0:       return {1'b0, 11'h7FF, 52'(1 + $urandom)};        // NaN
            1:       return {$urandom, $urandom};
            2:       return 64'(0);
            default: return $realtobits(real'($urandom_range(0, 2000)) - 1000.0);
        endcase
    endfunction

    function automatic void push_field(input logic [63:0] v, input int nbytes, input bit le);
        for (int i = 0; i < nbytes; i++)
            blob.push_back(le ? v[8*i +: 8] : v[8*(nbytes-1-i) +: 8]);
    endfunction

    // build a well-formed header, optionally broken or cut short
    function automatic void build_blob(input logic [7:0] flags, input logic [31:0] srid,
                                       input int cut, input bit extra);
        int n;
        logic [63:0] a;
        logic [63:0] b;
        blob.delete();
        blob.push_back(MAGIC_FIRST);
        blob.push_back(MAGIC_SECOND);
        blob.push_back(8'd0);
        blob.push_back(flags);
        push_field(64'(srid), 4, flags[0]);
        n = (flags[3:1] > MAX_CODE) ? 0 : axis_count(flags[3:1]);
        for (int i = 0; i < n; i++) begin
            a = rand_double();
            b = ($urandom_range(0, 1)) ? a : rand_double();
            if ($urandom_range(0, 2) != 0 && !nan_bits(a) && !nan_bits(b)
                    && greater_dbl(a, b)) begin
                push_field(b, 8, flags[0]);
                push_field(a, 8, flags[0]);
            end else begin
                push_field(a, 8, flags[0]);
                push_field(b, 8, flags[0]);
            end
        end
        if (extra) repeat ($urandom_range(1, 3)) blob.push_back(8'($urandom));
        if (cut > 0 && cut < blob.size()) blob = blob[0:cut-1];
    endfunction

    // output checker
    always @(posedge i_clk) begin
        t_hdr_result got;
        t_hdr_result want;
        if (i_rst_n && m_valid && m_ready) begin
            got.kind      = m_user;
            got.axis      = m_data[1:0];
            got.mn        = m_data[65:2];
            got.mx        = m_data[129:66];
            got.status    = m_data[132:130];
            got.is_empty  = m_data[133];
            got.env_kind  = m_data[136:134];
            got.little    = m_data[137];
            got.srid      = m_data[169:138];
            got.hdr_bytes = m_data[176:170];
            got.last      = m_last;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected transfer %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_data[183:177] !== 7'd0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("expected %h\n  actual %h", want, got);
                end
            end
        end
    end

    // sink ready with random stall bursts and an optional long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            sink_idle <= 0;
        end else if (sink_hold) begin
            m_ready <= 1'b0;
        end else if (sink_idle > 0) begin
            m_ready   <= 1'b0;
            sink_idle <= sink_idle - 1;
        end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
            m_ready   <= 1'b0;
            sink_idle <= int'($urandom_range(0, 6));
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on transfer-free cycles
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("geometry_blob_header_parser: mismatch");
            $finish;
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // both marks on one byte, bad magic, bad version, bad code
        send_byte(8'h47, 1, 1);
        send_byte(8'hFF, 0, 0);
        send_byte(8'h00, 1, 0); send_byte(8'h50, 0, 0);
        send_byte(8'h47, 1, 0); send_byte(8'h50, 0, 0); send_byte(8'hFF, 0, 1);
        build_blob(8'h0E, 32'h8000_0000, 0, 0); send_blob();
        build_blob(8'h08, 32'h7FFF_FFFF, 0, 1); send_blob();
        // empty flag with a random envelope, truncated in the middle of a pair
        blob.delete();
        build_blob(8'h13, 32'hFFFF_FFFF, 0, 0); send_blob();
        build_blob(8'h09, 32'd4326, 30, 0); send_blob();
        drain();
    endtask

    task automatic test_all_codes();
        for (int c = 0; c < 8; c++) begin
            build_blob(8'({$urandom_range(0, 7), 3'(c), 1'($urandom)}), $urandom,
                       0, 1'($urandom_range(0, 1)));
            send_blob();
        end
        drain();
    endtask

    // long receiver hold while the sender keeps offering bytes
    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            repeat (4) begin
                build_blob(8'h08, $urandom, 0, 0);
                send_blob();
            end
        join
        drain();
    endtask

    task automatic test_random(input int nbytes);
        int sent;
        int r;
        sent = 0;
        while (sent < nbytes) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                blob.delete();
                repeat ($urandom_range(1, 6)) blob.push_back(8'($urandom));
            end else if (r == 1) begin
                build_blob(8'($urandom), $urandom, $urandom_range(1, 40), 0);
            end else begin
                build_blob(8'({$urandom_range(0, 7), 3'($urandom_range(0, 4)),
                               1'($urandom)}), $urandom, (r == 2) ? $urandom_range(1, 72) : 0,
                           1'($urandom_range(0, 1)));
            end
            send_blob();
            sent += blob.size();
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0; s_data = 8'd0; s_user = 1'b0; s_last = 1'b0;
        m_ready = 1'b0;
        mismatch_cnt = 0; idle_cycles = 0;
        src_gaps = 1; sink_gaps = 1; sink_hold = 0;
        pm_pos = 0; pm_flags = 0; pm_word = 0; pm_srid = 0;
        pm_min = 0; pm_env_err = 0; pm_done = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_all_codes();
        test_backpressure();
        test_random(420);
        src_gaps = 0; sink_gaps = 0;
        test_random(180);
        if (mismatch_cnt == 0) $display("geometry_blob_header_parser: match");
        else $display("geometry_blob_header_parser: mismatch");
        $finish;
    end
endmodule

// ===== geometry_blob_header_parser.f =====
sv/gbhp_pkg.sv
sv/gbhp_front.sv
sv/gbhp_queue.sv
sv/gbhp_back.sv
sv/geometry_blob_header_parser.sv
tb/sv/tb.sv
